@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is high
`define ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

@@ rtl/lmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmpc_pkg
// shared types and constants of the led mode pattern controller
// ----------------------------------------------------------------------------
`default_nettype none

package lmpc_pkg;

   localparam int unsigned CsrAddrWidth = 4;

   localparam logic [7:0]  DebounceTicksReset = 8'd30;
   localparam logic [15:0] BlinkPeriodReset   = 16'd500;
   localparam logic [15:0] FadePeriodReset    = 16'd10;
   localparam logic [7:0]  FadeIncrementReset = 8'd5;

   localparam logic [7:0]  DutyFull   = 8'd255;
   localparam logic [7:0]  QuietMax   = 8'd255;
   localparam logic [15:0] ElapsedMax = 16'hFFFF;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_DEBOUNCE_TICKS = 2'd0,
      REG_BLINK_PERIOD   = 2'd1,
      REG_FADE_PERIOD    = 2'd2,
      REG_FADE_INCREMENT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_ON     = 2'd1,
      MODE_BLINK  = 2'd2,
      MODE_FADE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] blink_period;
      logic [15:0] fade_period;
      logic [7:0]  fade_increment;
   } cfg_type;

   typedef struct packed {
      logic cycle_press;
      logic clear_press;
   } press_type;

   typedef struct packed {
      logic [1:0] current_mode;
      logic [7:0] red_duty;
      logic [7:0] green_duty;
      logic [7:0] yellow_duty;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/led_mode_pattern_controller.sv @@
// ----------------------------------------------------------------------------
// led_mode_pattern_controller
// two-button led mode controller with debounce, blink and fade patterns
// ----------------------------------------------------------------------------
// Each req item is one millisecond tick with the raw active-low levels of
// the cycle and clear buttons; each tick yields exactly one rsp item with
// the yellow, green and red duties and the current mode. The block takes
// one item per clock cycle while rsp keeps up: an item is held in the
// input register, the debouncers and the pattern logic update their
// state in a single pass, and the result lands in the rsp output register,
// from which it is offered on rsp. With rsp always ready the block takes
// and returns one item every cycle; while rsp holds off, at most two items
// sit in the block (one in each register) before req_tready drops.
// Configuration registers sit on the csr port at byte addresses 0, 4, 8
// and 12 (debounce ticks, blink period, fade period, fade increment) and
// are meant to be written while no item is in flight. No clearing pass
// follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module led_mode_pattern_controller
   import lmpc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // req channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,   // [0] cycle_button, [1] clear_button
   // rsp channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [31:0]                  rsp_tdata,   // [7:0] yellow_duty, [15:8] green_duty,
                                                     // [23:16] red_duty, [25:24] current_mode
   // csr port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   // configuration registers
   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_raw_ff, in_raw_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;

   logic       advance;
   press_type  press;

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_pwdata[7:0];
            REG_BLINK_PERIOD:   cfg_in.blink_period   = csr_pwdata[15:0];
            REG_FADE_PERIOD:    cfg_in.fade_period    = csr_pwdata[15:0];
            REG_FADE_INCREMENT: cfg_in.fade_increment = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         REG_DEBOUNCE_TICKS: csr_prdata = {24'd0, cfg_ff.debounce_ticks};
         REG_BLINK_PERIOD:   csr_prdata = {16'd0, cfg_ff.blink_period};
         REG_FADE_PERIOD:    csr_prdata = {16'd0, cfg_ff.fade_period};
         REG_FADE_INCREMENT: csr_prdata = {24'd0, cfg_ff.fade_increment};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DebounceTicksReset;
         cfg_ff.blink_period   <= BlinkPeriodReset;
         cfg_ff.fade_period    <= FadePeriodReset;
         cfg_ff.fade_increment <= FadeIncrementReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- flow control ----------------
   // the stored tick is processed once the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_raw_in   = in_raw_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_raw_in   = req_tdata[1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_raw_ff <= in_raw_in;
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // ---------------- tick processing ----------------
   // cycle button debouncer
   lmpc_debounce u_cycle_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .raw            (in_raw_ff[0]),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .press          (press.cycle_press)
   );

   // clear button debouncer
   lmpc_debounce u_clear_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .raw            (in_raw_ff[1]),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .press          (press.clear_press)
   );

   // mode, timers and duties
   lmpc_pattern u_pattern (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .press  (press),
      .cfg    (cfg_ff),
      .result (out_data_in)
   );

   // ---------------- rsp ----------------
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff.current_mode, out_data_ff.red_duty,
                        out_data_ff.green_duty, out_data_ff.yellow_duty};

   // ---------------- assertions ----------------
   `ASSERT_IMPL(a_ready_only_stalls_when_full, clock, reset, !req_tready,
      in_valid_ff && out_valid_ff && !rsp_tready, "req stalled without a full pipeline")
   `ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, rsp_tvalid,
      "processed tick left no result")
   `ASSERT_NEXT(a_csr_debounce_write, clock, reset,
      csr_write && (csr_index == REG_DEBOUNCE_TICKS),
      cfg_ff.debounce_ticks == $past(csr_pwdata[7:0]), "debounce ticks write lost")

endmodule

`default_nettype wire

@@ rtl/lmpc_debounce.sv @@
// ----------------------------------------------------------------------------
// lmpc_debounce
// quiet-time debouncer for one active-low button, flags a debounced press
// ----------------------------------------------------------------------------
`default_nettype none

module lmpc_debounce
   import lmpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       enable,
   input  wire logic       raw,
   input  wire logic [7:0] debounce_ticks,
   output logic            press
);

   logic       last_raw_ff, last_raw_in;
   logic       stable_ff, stable_in;
   logic [7:0] quiet_ff, quiet_in;
   logic       accept;

   always_comb begin
      last_raw_in = raw;
      if (raw != last_raw_ff) begin
         quiet_in = 8'd0;
      end else if (quiet_ff != QuietMax) begin
         quiet_in = quiet_ff + 8'd1;
      end else begin
         quiet_in = quiet_ff;
      end
      accept    = (quiet_in >= debounce_ticks) && (stable_ff != raw);
      stable_in = accept ? raw : stable_ff;
      press     = accept && stable_ff && !raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b1;
         stable_ff   <= 1'b1;
         quiet_ff    <= 8'd0;
      end else if (enable) begin
         last_raw_ff <= last_raw_in;
         stable_ff   <= stable_in;
         quiet_ff    <= quiet_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lmpc_pattern.sv @@
// ----------------------------------------------------------------------------
// lmpc_pattern
// mode register, blink and fade timers, duty generation
// ----------------------------------------------------------------------------
`default_nettype none

module lmpc_pattern
   import lmpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       enable,
   input  wire press_type  press,
   input  wire cfg_type    cfg,
   output result_type      result
);

   mode_type    mode_ff, mode_in;
   logic        phase_ff, phase_in;
   logic [15:0] blink_el_ff, blink_el_in;
   logic [7:0]  level_ff, level_in;
   logic        rising_ff, rising_in;
   logic [15:0] fade_el_ff, fade_el_in;
   logic [7:0]  duty_ff [3];
   logic [7:0]  duty_in [3];

   always_comb begin
      logic signed [9:0] lvl;
      lvl = 10'sd0;
      blink_el_in = (blink_el_ff != ElapsedMax) ? blink_el_ff + 16'd1 : blink_el_ff;
      fade_el_in  = (fade_el_ff != ElapsedMax) ? fade_el_ff + 16'd1 : fade_el_ff;
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      level_in    = level_ff;
      rising_in   = rising_ff;
      duty_in     = duty_ff;

      // restart on any press, clear press taken last so it wins
      if (press.cycle_press) begin
         mode_in = mode_type'(mode_ff + 2'd1);
      end
      if (press.clear_press) begin
         mode_in = MODE_OFF;
      end
      if (press.cycle_press || press.clear_press) begin
         phase_in    = 1'b0;
         blink_el_in = 16'd0;
         fade_el_in  = 16'd0;
         level_in    = 8'd0;
         rising_in   = 1'b1;
      end

      unique case (mode_in)
         MODE_OFF: begin
            duty_in = '{8'd0, 8'd0, 8'd0};
         end
         MODE_ON: begin
            duty_in = '{DutyFull, DutyFull, DutyFull};
         end
         MODE_BLINK: begin
            if (blink_el_in >= cfg.blink_period) begin
               phase_in    = !phase_in;
               blink_el_in = 16'd0;
            end
            if (phase_in) duty_in = '{DutyFull, 8'd0, DutyFull};
            else          duty_in = '{8'd0, DutyFull, 8'd0};
         end
         MODE_FADE: begin
            if (fade_el_in >= cfg.fade_period) begin
               if (rising_in) begin
                  lvl = $signed({2'b00, level_in}) + $signed({2'b00, cfg.fade_increment});
               end else begin
                  lvl = $signed({2'b00, level_in}) - $signed({2'b00, cfg.fade_increment});
               end
               if (lvl >= 10'sd255) begin
                  level_in  = DutyFull;
                  rising_in = 1'b0;
               end else if (lvl <= 10'sd0) begin
                  level_in  = 8'd0;
                  rising_in = 1'b1;
               end else begin
                  level_in = lvl[7:0];
               end
               duty_in    = '{level_in, level_in, level_in};
               fade_el_in = 16'd0;
            end
         end
         default: begin
            duty_in = duty_ff;
         end
      endcase

      result.yellow_duty  = duty_in[0];
      result.green_duty   = duty_in[1];
      result.red_duty     = duty_in[2];
      result.current_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         phase_ff    <= 1'b0;
         blink_el_ff <= 16'd0;
         level_ff    <= 8'd0;
         rising_ff   <= 1'b1;
         fade_el_ff  <= 16'd0;
         duty_ff     <= '{8'd0, 8'd0, 8'd0};
      end else if (enable) begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         blink_el_ff <= blink_el_in;
         level_ff    <= level_in;
         rising_ff   <= rising_in;
         fade_el_ff  <= fade_el_in;
         duty_ff     <= duty_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_led_mode_pattern_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_mode_pattern_controller
// self-checking bench for the two-button led mode controller
// ----------------------------------------------------------------------------
// Ticks go in on the req stream and each one is run through a local model
// of the debouncers, the mode register and the blink and fade patterns. The
// expected duties and mode are queued and compared with every rsp item in
// order. The run walks the modes by hand with instant debounce, then sends
// random press, release and bounce runs under several register settings,
// covers the longest debounce and the longest periods, and fills the block
// while the rsp side holds off. Both sides idle at random, with a profile
// that changes over the run.
// ----------------------------------------------------------------------------

module tb_led_mode_pattern_controller;
   import lmpc_pkg::*;

   // per-button debounce tracking
   typedef struct {
      logic       last_raw;
      logic       stable;
      logic [7:0] quiet;
   } button_track_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = 8'hFF;   // [0] cycle_button, [1] clear_button
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [31:0]             rsp_tdata;           // [7:0] yellow, [15:8] green,
                                                 // [23:16] red, [25:24] current_mode
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // idle rates in percent, set per phase by the main sequence
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long rsp hold-off: the test bumps stall_requests, the rsp side counts
   int long_stall_cycles = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;

   int error_count = 0;

   // expected rsp items, oldest first
   result_type expected_duties[$];

   // local copy of the registers
   logic [7:0]  cfg_debounce;
   logic [15:0] cfg_blink;
   logic [15:0] cfg_fade;
   logic [7:0]  cfg_step;

   // local copy of the pattern state
   button_track_type cycle_track, clear_track;
   logic [1:0]    mode_q;
   logic          blink_on;
   logic [15:0]   blink_cnt;
   logic [7:0]    fade_level;
   logic          fade_up;
   logic [15:0]   fade_cnt;
   logic [7:0]    duty_y, duty_g, duty_r;

   led_mode_pattern_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // generous fixed limit, far above the slowest correct run
   initial begin
      #20_000_000;
      $display("tb_led_mode_pattern_controller failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // duty and mode prediction
   // ---------------------------------------------------------------------

   function automatic void reset_model();
      cfg_debounce = DebounceTicksReset;
      cfg_blink    = BlinkPeriodReset;
      cfg_fade     = FadePeriodReset;
      cfg_step     = FadeIncrementReset;
      cycle_track  = '{last_raw: 1'b1, stable: 1'b1, quiet: 8'd0};
      clear_track  = '{last_raw: 1'b1, stable: 1'b1, quiet: 8'd0};
      mode_q       = MODE_OFF;
      blink_on     = 1'b0;
      blink_cnt    = '0;
      fade_level   = '0;
      fade_up      = 1'b1;
      fade_cnt     = '0;
      {duty_y, duty_g, duty_r} = '0;
   endfunction

   // quiet-time debounce, returns 1 on a released to pressed change
   function automatic logic debounce_press(input logic raw, inout button_track_type b);
      logic press;
      press = 1'b0;
      if (raw != b.last_raw) begin
         b.last_raw = raw;
         b.quiet    = 8'd0;
      end else if (b.quiet != QuietMax) begin
         b.quiet = b.quiet + 8'd1;
      end
      if (b.quiet >= cfg_debounce && b.stable != raw) begin
         press    = b.stable & ~raw;
         b.stable = raw;
      end
      return press;
   endfunction

   function automatic void restart_patterns();
      blink_on   = 1'b0;
      blink_cnt  = '0;
      fade_cnt   = '0;
      fade_level = '0;
      fade_up    = 1'b1;
   endfunction

   function automatic result_type predict_tick(input logic cyc, input logic clr);
      result_type r;
      int         lvl;
      if (blink_cnt != ElapsedMax) blink_cnt = blink_cnt + 16'd1;
      if (fade_cnt != ElapsedMax) fade_cnt = fade_cnt + 16'd1;

      // cycle button first, clear button second so that clear wins
      if (debounce_press(cyc, cycle_track)) begin
         mode_q = mode_q + 2'd1;
         restart_patterns();
      end
      if (debounce_press(clr, clear_track)) begin
         mode_q = MODE_OFF;
         {duty_y, duty_g, duty_r} = '0;
         restart_patterns();
      end

      case (mode_q)
         MODE_OFF: begin
            {duty_y, duty_g, duty_r} = '0;
         end
         MODE_ON: begin
            {duty_y, duty_g, duty_r} = {DutyFull, DutyFull, DutyFull};
         end
         MODE_BLINK: begin
            if (blink_cnt >= cfg_blink) begin
               blink_on  = ~blink_on;
               blink_cnt = '0;
            end
            if (blink_on) {duty_y, duty_g, duty_r} = {DutyFull, 8'd0, DutyFull};
            else {duty_y, duty_g, duty_r} = {8'd0, DutyFull, 8'd0};
         end
         default: begin
            // fade: the duties only move on a step, otherwise they hold
            if (fade_cnt >= cfg_fade) begin
               if (fade_up) lvl = int'(fade_level) + int'(cfg_step);
               else lvl = int'(fade_level) - int'(cfg_step);
               if (lvl >= 255) begin
                  lvl     = 255;
                  fade_up = 1'b0;
               end
               if (lvl <= 0) begin
                  lvl     = 0;
                  fade_up = 1'b1;
               end
               fade_level = lvl[7:0];
               {duty_y, duty_g, duty_r} = {fade_level, fade_level, fade_level};
               fade_cnt = '0;
            end
         end
      endcase

      r.yellow_duty  = duty_y;
      r.green_duty   = duty_g;
      r.red_duty     = duty_r;
      r.current_mode = mode_q;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         // keep the log short when the block is badly off
         if (error_count <= 100)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   task automatic check_result(input logic [31:0] data);
      result_type want, got;
      if (expected_duties.size() == 0) begin
         error_count++;
         if (error_count <= 100)
            $display("%0t: rsp item with nothing expected, expected none, got %h",
                     $time, data);
         return;
      end
      want = expected_duties.pop_front();
      got  = data[25:0];
      check_field("yellow_duty", 32'(want.yellow_duty), 32'(got.yellow_duty));
      check_field("green_duty", 32'(want.green_duty), 32'(got.green_duty));
      check_field("red_duty", 32'(want.red_duty), 32'(got.red_duty));
      check_field("current_mode", 32'(want.current_mode), 32'(got.current_mode));
      check_field("rsp_tdata padding", 32'd0, 32'(data[31:26]));
   endtask

   // rsp side: check the item taken at this edge, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left   = long_stall_cycles;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // req and csr drivers
   // ---------------------------------------------------------------------

   // one tick item; returns at the edge that took it
   task automatic send_tick(input logic cyc, input logic clr);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, clr, cyc};
      do @(posedge clock); while (!req_tready);
      expected_duties.push_back(predict_tick(cyc, clr));
   endtask

   // press for one tick and release for one tick, meant for zero debounce
   task automatic tap(input logic cyc_press, input logic clr_press);
      send_tick(~cyc_press, ~clr_press);
      send_tick(1'b1, 1'b1);
   endtask

   // stop sending and wait until every expected item has come back
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (expected_duties.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_duties.size() != 0) begin
         error_count++;
         $display("%0t: %0d rsp items never came, expected %h, got none",
                  $time, expected_duties.size(), expected_duties[0]);
         expected_duties.delete();
      end
      // then idle past the input and result registers
      repeat (4) @(posedge clock);
   endtask

   // a setup phase and an access phase, then an idle phase on the bus
   task automatic csr_transfer(input logic wr, input reg_index_type idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_transfer(1'b0, idx, 32'd0, rd);
      check_field($sformatf("csr register %0d readback", idx), value, rd);
   endtask

   task automatic set_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_transfer(1'b1, idx, value, rd);
      case (idx)
         REG_DEBOUNCE_TICKS: cfg_debounce = value[7:0];
         REG_BLINK_PERIOD:   cfg_blink    = value[15:0];
         REG_FADE_PERIOD:    cfg_fade     = value[15:0];
         default:            cfg_step     = value[7:0];
      endcase
      check_register(idx, value);
   endtask

   // registers only change once the block has nothing in flight
   task automatic apply_config(input int debounce, input int blink, input int fade,
                               input int step);
      wait_results_drained();
      set_register(REG_DEBOUNCE_TICKS, debounce);
      set_register(REG_BLINK_PERIOD, blink);
      set_register(REG_FADE_PERIOD, fade);
      set_register(REG_FADE_INCREMENT, step);
   endtask

   // random button runs: mostly clean presses and releases held past the
   // debounce time, the rest short random runs that may or may not outlast it
   task automatic run_button_sequences(input int n_ticks);
      logic cyc, clr;
      int   hold, pick, sent;
      cyc  = 1'b1;
      clr  = 1'b1;
      sent = 0;
      while (sent < n_ticks) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            if (pick < 56) begin
               cyc = ~cyc;
            end else if (pick < 72) begin
               clr = ~clr;
            end else begin
               cyc = 1'($urandom_range(1));
               clr = 1'($urandom_range(1));
            end
            hold = cfg_debounce + 1 + $urandom_range(0, 30);
         end else begin
            cyc  = 1'($urandom_range(1));
            clr  = 1'($urandom_range(1));
            hold = $urandom_range(1, cfg_debounce + 1);
         end
         repeat (hold) send_tick(cyc, clr);
         sent += hold;
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // registers come up at their reset values and the block starts off
   task automatic test_reset_values();
      check_register(REG_DEBOUNCE_TICKS, 32'(DebounceTicksReset));
      check_register(REG_BLINK_PERIOD, 32'(BlinkPeriodReset));
      check_register(REG_FADE_PERIOD, 32'(FadePeriodReset));
      check_register(REG_FADE_INCREMENT, 32'(FadeIncrementReset));
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
   endtask

   // walk every mode by hand with zero debounce and the shortest periods
   task automatic test_mode_walk();
      apply_config(0, 1, 1, 255);
      tap(1'b1, 1'b0);                 // on
      tap(1'b1, 1'b0);                 // blink, toggles every tick
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      tap(1'b1, 1'b0);                 // fade, duties hold until the first step
      send_tick(1'b1, 1'b1);           // full step clamps at top and bottom
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      tap(1'b1, 1'b0);                 // wraps back to off
      tap(1'b1, 1'b0);                 // on
      tap(1'b1, 1'b1);                 // both in one tick, clear wins
      tap(1'b1, 1'b0);                 // on
      tap(1'b0, 1'b1);                 // clear alone
   endtask

   // random register setting with short debounce and periods
   task automatic test_random_patterns(input int n_ticks);
      int debounce, blink, fade, step;
      debounce = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      blink    = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 20);
      fade     = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
      case ($urandom_range(3))
         0:       step = 1;
         1:       step = 255;
         default: step = $urandom_range(2, 254);
      endcase
      apply_config(debounce, blink, fade, step);
      run_button_sequences(n_ticks);
   endtask

   // longest debounce, quiet counter runs into its ceiling
   task automatic test_long_debounce();
      apply_config(255, 3, 2, $urandom_range(1, 255));
      repeat (258) send_tick(1'b0, 1'b1);   // held press, taken once quiet tops out
      repeat (4) send_tick(1'b1, 1'b1);     // short release, filtered out
   endtask

   // rsp holds off while req keeps offering, then req waits for the drain
   task automatic test_backpressure();
      apply_config(2, 4, 3, 40);
      long_stall_cycles = 300;
      stall_requests++;
      repeat (30) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      wait_results_drained();
      repeat (10) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // longest blink and fade periods, no toggle and no fade step in the run
   task automatic test_long_idle();
      apply_config(0, 65535, 65535, 1);
      tap(1'b0, 1'b1);                 // off from wherever the last phase left it
      tap(1'b1, 1'b0);
      tap(1'b1, 1'b0);                 // blink
      repeat (20) send_tick(1'b1, 1'b1);
      tap(1'b1, 1'b0);                 // fade
      repeat (20) send_tick(1'b1, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles less than the receiver
      send_idle_pct = 32;
      recv_idle_pct = 68;
      test_reset_values();
      test_mode_walk();
      test_random_patterns(40);

      // the other way round
      send_idle_pct = 68;
      recv_idle_pct = 32;
      test_long_debounce();
      test_random_patterns(40);
      test_backpressure();

      // no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_patterns(40);
      test_long_idle();

      wait_results_drained();
      if (error_count == 0) begin
         $display("tb_led_mode_pattern_controller passed");
      end else begin
         $display("tb_led_mode_pattern_controller failed");
      end
      $finish;
   end

endmodule
